// ===== hw/rtl/jhsi_pkg.sv =====
// shared types, constants and phase table generator for the joint home setpoint interpolator
`default_nettype none

package jhsi_pkg;

	// fixed field layout of the stream ports
	localparam int FIELD_JOINTS = 6;
	localparam int IN_TDATA_W = 248;
	localparam int OUT_TDATA_W = 216;

	localparam logic [16:0] PROGRESS_ONE = 17'h10000;
	localparam logic [63:0] Q30_ONE = 64'h0000_0000_4000_0000;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_ENTER = 2'd1,
		CMD_LOAD  = 2'd2,
		CMD_IDLE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_SWITCH_BASE   = 2'd0,
		CFG_POSE_COUNT    = 2'd1,
		CFG_PROGRESS_STEP = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic hold;
		logic consumed;
		logic switched;
	} jhsi_flags_t;

	// restoring long division, used only while building the phase table
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// tanh(3k/depth) in Q0.16, series start then eight fixed-point refinement steps
	function automatic logic [15:0] phase_entry(int unsigned k, int unsigned depth);
		logic [63:0] x;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] a3;
		logic [63:0] a5;
		logic [63:0] t;
		logic [63:0] den;
		logic [63:0] r;
		x = udiv64((64'(k) * 64'd3) << 30, 64'(depth));
		a = x >> 8;
		a2 = (a * a) >> 30;
		a3 = (a2 * a) >> 30;
		a5 = (a3 * a2) >> 30;
		t = a - a3 / 64'd3 + (64'd2 * a5) / 64'd15;
		for (int i = 0; i < 8; i++) begin
			den = Q30_ONE + ((t * t) >> 30);
			t = udiv64(t << 31, den);
		end
		r = (t + 64'd8192) >> 14;
		return r[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/joint_home_setpoint_interpolator.sv =====
// Joint home setpoint interpolator: top level with pose table memories and drive pipeline
//
// Takes one item per clock unless the output side stalls, and returns one result per item
// through stages s1, s2 and the output register. Pose selection, progress and start points
// are updated in the cycle an item is accepted; the pose table sits in one synchronous
// memory per joint, read at the pose chosen in that cycle, so a load item sees its own
// write through a forward path. The next cycle looks up the tanh phase and forms
// target - start, the one after multiplies by the phase, and the result lands in the
// output register. A stall on the output freezes the whole pipeline. Pose table words
// hold no defined value until loaded. Configuration writes are taken every cycle.
`default_nettype none

module joint_home_setpoint_interpolator
	import jhsi_pkg::*;
#(
	parameter int NUM_JOINTS = 6,
	parameter int NUM_POSES = 8,
	parameter int PHASE_TABLE_DEPTH = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// command_value, measured_0..measured_5, load_pose, load_joint, load_value, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  wire logic [1:0]             s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// drive_0..drive_5, active_pose, progress_now, pose_switched, command_consumed,
	// hold_request, zero pad
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [16:0]            cfg_data
);

	localparam int PIW = $clog2(NUM_POSES);
	localparam int CW = $clog2(NUM_POSES + 1);
	localparam int DW = $clog2(PHASE_TABLE_DEPTH + 1);
	localparam int PPW = 17 + DW;

	// configuration
	logic [14:0] switch_base_q;
	logic [3:0]  pose_count_q;
	logic [16:0] progress_step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_base_q <= 15'd3;
			pose_count_q <= 4'd1;
			progress_step_q <= 17'd22;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SWITCH_BASE:   switch_base_q <= cfg_data[14:0];
				CFG_POSE_COUNT:    pose_count_q <= cfg_data[3:0];
				CFG_PROGRESS_STEP: progress_step_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input fields
	cmd_t               cmd;
	logic signed [15:0] value;
	logic [31:0]        meas [FIELD_JOINTS];
	logic [2:0]         load_pose;
	logic [2:0]         load_joint;
	logic [31:0]        load_value;

	assign cmd = cmd_t'(s_tuser);
	assign value = s_tdata[15:0];
	assign load_pose = s_tdata[210:208];
	assign load_joint = s_tdata[213:211];
	assign load_value = s_tdata[245:214];

	always_comb begin
		for (int j = 0; j < FIELD_JOINTS; j++) begin
			meas[j] = s_tdata[16 + 32 * j +: 32];
		end
	end

	// whole pipeline advances together; the output register parts it from the sink
	logic adv;
	logic s_acc;

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign s_acc = s_tvalid && s_tready;

	// state registers
	logic [PIW-1:0] pose_q;
	logic [16:0]    progress_q;
	logic [15:0]    prev_cmd_q;

	// switch decode
	logic [4:0]         pc5;
	logic [CW-1:0]      eff_count;
	logic signed [16:0] val17;
	logic signed [16:0] base17;
	logic signed [16:0] sel17;
	logic               is_switch;
	logic               is_base;
	logic               sel_ok;
	logic               changed;
	logic               tick_switch;
	logic [CW-1:0]      cyc_r;
	logic [17:0]        prog_sum;
	logic [16:0]        prog_adv;

	always_comb begin
		pc5 = {1'b0, pose_count_q};
		if (pc5 == 5'd0) begin
			eff_count = CW'(1);
		end else if (pc5 > 5'(NUM_POSES)) begin
			eff_count = CW'(NUM_POSES);
		end else begin
			eff_count = CW'(pc5);
		end
	end

	assign val17 = {value[15], value};
	assign base17 = {2'b00, switch_base_q};
	assign sel17 = val17 - base17 - 17'sd1;
	assign is_switch = val17 >= base17;
	assign is_base = val17 == base17;
	assign sel_ok = sel17 < 17'(eff_count);
	assign changed = value != prev_cmd_q;
	assign tick_switch = is_switch && changed && (eff_count >= CW'(2)) && (is_base || sel_ok);

	// next pose when cycling; index can be stale after a count change
	always_comb begin
		cyc_r = CW'(pose_q) + CW'(1);
		for (int i = 0; i < NUM_POSES / 2; i++) begin
			if (cyc_r >= eff_count) begin
				cyc_r = cyc_r - eff_count;
			end
		end
	end

	always_comb begin
		prog_sum = (tick_switch ? 18'd0 : {1'b0, progress_q}) + {1'b0, progress_step_q};
		if (prog_sum > {1'b0, PROGRESS_ONE}) begin
			prog_adv = PROGRESS_ONE;
		end else begin
			prog_adv = prog_sum[16:0];
		end
	end

	logic [PIW-1:0] pose_nx;
	logic [16:0]    prog_nx;
	logic           capture;
	jhsi_flags_t    flags_nx;

	always_comb begin
		pose_nx = pose_q;
		prog_nx = progress_q;
		capture = 1'b0;
		flags_nx = '0;
		unique case (cmd)
			CMD_TICK: begin
				if (tick_switch) begin
					pose_nx = is_base ? PIW'(cyc_r) : PIW'(sel17);
				end
				prog_nx = prog_adv;
				capture = tick_switch;
				flags_nx.switched = tick_switch;
				flags_nx.consumed = is_switch;
				flags_nx.hold = value == 16'sd2;
			end
			CMD_ENTER: begin
				pose_nx = '0;
				prog_nx = '0;
				capture = 1'b1;
				flags_nx.switched = 1'b1;
			end
			CMD_LOAD, CMD_IDLE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q <= '0;
			progress_q <= '0;
			prev_cmd_q <= '0;
		end else if (s_acc) begin
			pose_q <= pose_nx;
			progress_q <= prog_nx;
			if (cmd == CMD_TICK) begin
				prev_cmd_q <= value;
			end
		end
	end

	// pose table write decode
	logic           load_in_range;
	logic [PIW-1:0] wr_row;

	assign load_in_range = (32'(load_pose) < NUM_POSES) && (32'(load_joint) < NUM_JOINTS);
	assign wr_row = PIW'(load_pose);

	// pipeline control and shared payload
	logic           vld_s1;
	logic           vld_s2;
	logic [16:0]    progress_s1;
	logic [16:0]    progress_s2;
	logic [16:0]    progress_q_out;
	logic [PIW-1:0] pose_s1;
	logic [PIW-1:0] pose_s2;
	logic [PIW-1:0] pose_q_out;
	jhsi_flags_t    flags_s1;
	jhsi_flags_t    flags_s2;
	jhsi_flags_t    flags_q;
	logic [31:0]    fwd_val_s1;
	logic [15:0]    phase_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			m_tvalid <= vld_s2;
		end
	end

	// phase table, built at elaboration
	logic [15:0]    phase_rom [PHASE_TABLE_DEPTH + 1];
	logic [PPW-1:0] pidx_prod;
	logic [DW-1:0]  pidx;

	for (genvar k = 0; k <= PHASE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [15:0] PHASE_ENTRY =
			phase_entry(k, PHASE_TABLE_DEPTH);
		assign phase_rom[k] = PHASE_ENTRY;
	end

	// progress never exceeds one, so the index never exceeds the table depth
	assign pidx_prod = PPW'(progress_s1) * PPW'(PHASE_TABLE_DEPTH);
	assign pidx = pidx_prod[16 +: DW];

	always_ff @(posedge clk) begin
		if (adv) begin
			progress_s1 <= prog_nx;
			pose_s1 <= pose_nx;
			flags_s1 <= flags_nx;
			fwd_val_s1 <= load_value;
			progress_s2 <= progress_s1;
			pose_s2 <= pose_s1;
			flags_s2 <= flags_s1;
			phase_s2 <= phase_rom[pidx];
			progress_q_out <= progress_s2;
			pose_q_out <= pose_s2;
			flags_q <= flags_s2;
		end
	end

	// per joint lanes: pose table memory, start point, interpolation
	logic [31:0] drive_w [FIELD_JOINTS];

	for (genvar j = 0; j < FIELD_JOINTS; j++) begin : g_joint
		if (j < NUM_JOINTS) begin : g_lane
			logic [31:0]        mem [NUM_POSES];
			logic               wr_en;
			logic [31:0]        start_q;
			logic [31:0]        rd_s1;
			logic [31:0]        start_s1;
			logic               fwd_s1;
			logic [31:0]        tgt;
			logic signed [32:0] diff;
			logic signed [32:0] diff_s2;
			logic [31:0]        start_s2;
			logic signed [49:0] prod;
			logic [31:0]        drive_q;

			assign wr_en = s_acc && (cmd == CMD_LOAD) && load_in_range &&
				(load_joint == 3'(j));

			always_ff @(posedge clk) begin
				if (wr_en) begin
					mem[wr_row] <= load_value;
				end
				if (adv) begin
					rd_s1 <= mem[pose_nx];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					start_q <= '0;
				end else if (s_acc && capture) begin
					start_q <= meas[j];
				end
			end

			// a load reads its own row in the cycle it writes it
			always_ff @(posedge clk) begin
				if (adv) begin
					start_s1 <= capture ? meas[j] : start_q;
					fwd_s1 <= wr_en && (wr_row == pose_nx);
					diff_s2 <= diff;
					start_s2 <= start_s1;
					drive_q <= start_s2 + prod[47:16];
				end
			end

			assign tgt = fwd_s1 ? fwd_val_s1 : rd_s1;
			assign diff = $signed({tgt[31], tgt}) - $signed({start_s1[31], start_s1});
			// round half up, then floor by the arithmetic shift in the part-select
			assign prod = diff_s2 * $signed({1'b0, phase_s2}) + 50'sd32768;
			assign drive_w[j] = drive_q;
		end else begin : g_pad
			assign drive_w[j] = '0;
		end
	end

	assign m_tdata[191:0] = {drive_w[5], drive_w[4], drive_w[3],
		drive_w[2], drive_w[1], drive_w[0]};
	assign m_tdata[194:192] = 3'(pose_q_out);
	assign m_tdata[211:195] = progress_q_out;
	assign m_tdata[212] = flags_q.switched;
	assign m_tdata[213] = flags_q.consumed;
	assign m_tdata[214] = flags_q.hold;
	assign m_tdata[215] = 1'b0;

	a_progress_max: assert property (@(posedge clk) disable iff (!arst_n)
		progress_q <= PROGRESS_ONE)
		else $error("progress above one");

	a_pose_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pose_q) < NUM_POSES)
		else $error("pose index beyond table");

	a_enter_reset: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (cmd == CMD_ENTER) |=> (progress_q == '0) && (pose_q == '0))
		else $error("enter did not restart at pose zero");

	a_load_keeps_pose: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && ((cmd == CMD_LOAD) || (cmd == CMD_IDLE)) |=>
		$stable(pose_q) && $stable(progress_q))
		else $error("load or idle changed interpolation state");

	a_pipe_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s2 |=> m_tvalid)
		else $error("result lost on the way to the output register");

endmodule

`default_nettype wire

// ===== tb/tb_joint_home_setpoint_interpolator.sv =====
// self-checking stream testbench for the joint home setpoint interpolator
module tb_joint_home_setpoint_interpolator;
	import jhsi_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_PHASE_ITEMS = 140;
	localparam int NJ = 6;
	localparam int NP = 8;
	localparam int PHASE_DEPTH = 256;

	// command_value, measured_0..5, load_pose, load_joint, load_value, pad (lowest first)
	typedef struct packed {
		logic [1:0]        pad;
		logic [31:0]       load_value;
		logic [2:0]        load_joint;
		logic [2:0]        load_pose;
		logic [5:0][31:0]  measured;
		logic [15:0]       command_value;
	} home_in_t;

	typedef struct {
		cmd_t     cmd;
		home_in_t d;
	} home_item_t;

	// drive_0..5, active_pose, progress_now, switched, consumed, hold, pad (lowest first)
	typedef struct packed {
		logic              pad;
		jhsi_flags_t       flags;
		logic [16:0]       progress;
		logic [2:0]        pose;
		logic [5:0][31:0]  drive;
	} home_out_t;

	typedef struct {
		home_out_t  w;
		logic [5:0] known;
	} setpoint_exp_t;

	class setpoint_scoreboard;
		logic signed [31:0] targets[NP][NJ];
		bit                 loaded[NP][NJ];
		logic signed [31:0] start_pt[NJ];
		int                 progress_q16;
		int                 pose;
		logic [15:0]        last_cmd_value;
		int                 switch_base;
		int                 pose_count;
		int                 step_q16;
		int                 tanh_rom[PHASE_DEPTH + 1];
		setpoint_exp_t      setpoints_due[$];
		int                 errors;
		int                 n_checked;
		int                 n_switched;
		int                 n_by_cmd[4];

		function new();
			for (int k = 0; k <= PHASE_DEPTH; k++)
				tanh_rom[k] = tanh_entry(k);
			for (int j = 0; j < NJ; j++)
				start_pt[j] = '0;
			progress_q16 = 0;
			pose = 0;
			last_cmd_value = '0;
			switch_base = 3;
			pose_count = 1;
			step_q16 = 22;
		endfunction

		// tanh(3k/depth) in Q0.16: series seed, then eight Q30 refinement steps
		function int tanh_entry(int k);
			longint unsigned x, a, a2, a3, a5, t, den;
			x = ((64'(k) * 64'd3) << 30) / 64'(PHASE_DEPTH);
			a = x >> 8;
			a2 = (a * a) >> 30;
			a3 = (a2 * a) >> 30;
			a5 = (a3 * a2) >> 30;
			t = a - a3 / 64'd3 + (64'd2 * a5) / 64'd15;
			for (int i = 0; i < 8; i++) begin
				den = 64'h4000_0000 + ((t * t) >> 30);
				t = (t << 31) / den;
			end
			return int'((t + 64'd8192) >> 14);
		endfunction

		function void set_reg(cfg_idx_t idx, logic [16:0] v);
			case (idx)
				CFG_SWITCH_BASE: begin
					switch_base = int'(v[14:0]);
				end
				CFG_POSE_COUNT: begin
					pose_count = int'(v[3:0]);
				end
				CFG_PROGRESS_STEP: begin
					step_q16 = int'(v);
				end
				default: ;
			endcase
		endfunction

		function int poses_in_use();
			if (pose_count < 1)
				return 1;
			if (pose_count > NP)
				return NP;
			return pose_count;
		endfunction

		function void capture(home_in_t d);
			for (int j = 0; j < NJ; j++)
				start_pt[j] = d.measured[j];
			progress_q16 = 0;
		endfunction

		function setpoint_exp_t form_setpoint();
			setpoint_exp_t e;
			longint s, tg, p, ph;
			int idx;
			idx = (progress_q16 * PHASE_DEPTH) >> 16;
			if (idx > PHASE_DEPTH)
				idx = PHASE_DEPTH;
			ph = tanh_rom[idx];
			e.w = '0;
			for (int j = 0; j < NJ; j++) begin
				s = longint'(start_pt[j]);
				tg = longint'(targets[pose][j]);
				// rounded, floored toward minus infinity
				p = (tg - s) * ph + 64'sd32768;
				e.w.drive[j] = 32'(s + (p >>> 16));
				e.known[j] = loaded[pose][j];
			end
			e.w.pose = 3'(pose);
			e.w.progress = 17'(progress_q16);
			return e;
		endfunction

		function void note_item(home_item_t it);
			setpoint_exp_t e;
			int value, sel, cnt;
			bit sw, is_sw;
			sw = 1'b0;
			is_sw = 1'b0;
			n_by_cmd[int'(it.cmd)]++;
			value = int'($signed(it.d.command_value));
			case (it.cmd)
				CMD_TICK: begin
					cnt = poses_in_use();
					is_sw = value >= switch_base;
					if (is_sw && it.d.command_value != last_cmd_value && cnt >= 2) begin
						if (value == switch_base) begin
							pose = (pose + 1) % cnt;
							sw = 1'b1;
						end else begin
							sel = value - switch_base - 1;
							if (sel < cnt) begin
								pose = sel;
								sw = 1'b1;
							end
						end
						if (sw)
							capture(it.d);
					end
					last_cmd_value = it.d.command_value;
					progress_q16 += step_q16;
					if (progress_q16 > 65536)
						progress_q16 = 65536;
				end
				CMD_ENTER: begin
					pose = 0;
					capture(it.d);
					sw = 1'b1;
				end
				CMD_LOAD: begin
					if (it.d.load_joint < NJ) begin
						targets[it.d.load_pose][it.d.load_joint] = it.d.load_value;
						loaded[it.d.load_pose][it.d.load_joint] = 1'b1;
					end
				end
				default: ;
			endcase
			e = form_setpoint();
			e.w.flags.switched = sw;
			e.w.flags.consumed = is_sw;
			e.w.flags.hold = (it.cmd == CMD_TICK) && (value == 2);
			if (sw)
				n_switched++;
			setpoints_due.insert(setpoints_due.size(), e);
		endfunction

		function void cmp(string what, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
				errors++;
			end
		endfunction

		function void check_setpoint(home_out_t got);
			setpoint_exp_t e;
			n_checked++;
			if (setpoints_due.size() == 0) begin
				$display("%0t: setpoint with none due, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = setpoints_due.pop_front();
			for (int j = 0; j < NJ; j++)
				if (e.known[j])
					cmp($sformatf("drive_%0d", j), e.w.drive[j], got.drive[j]);
			cmp("active_pose", 32'(e.w.pose), 32'(got.pose));
			cmp("progress_now", 32'(e.w.progress), 32'(got.progress));
			cmp("pose_switched", 32'(e.w.flags.switched), 32'(got.flags.switched));
			cmp("command_consumed", 32'(e.w.flags.consumed), 32'(got.flags.consumed));
			cmp("hold_request", 32'(e.w.flags.hold), 32'(got.flags.hold));
			cmp("pad", 32'(1'b0), 32'(got.pad));
		endfunction

		function int pending();
			return setpoints_due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = '0;
	logic [16:0]            cfg_data = '0;

	setpoint_scoreboard board;
	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int cur_base = 3;
	int cur_count = 1;
	int n_settings = 0;

	joint_home_setpoint_interpolator dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic home_item_t item_of(cmd_t c, int v);
		home_item_t it;
		it.cmd = c;
		it.d.pad = '0;
		it.d.command_value = 16'(v);
		for (int j = 0; j < NJ; j++)
			it.d.measured[j] = rand_word();
		it.d.load_pose = 3'($urandom_range(0, 7));
		it.d.load_joint = 3'($urandom_range(0, 7));
		it.d.load_value = rand_word();
		return it;
	endfunction

	function automatic home_item_t random_item();
		int r, cnt;
		r = $urandom_range(0, 99);
		cnt = (cur_count < 1) ? 1 : (cur_count > NP) ? NP : cur_count;
		// mostly switch commands around the base, so poses keep changing
		if (r < 45)
			return item_of(CMD_TICK, cur_base + int'($urandom_range(0, cnt + 1)));
		if (r < 62)
			return item_of(CMD_TICK, cur_base - int'($urandom_range(1, 6)));
		if (r < 66)
			return item_of(CMD_TICK, 2);
		if (r < 72)
			return item_of(CMD_TICK, int'($urandom_range(0, 65535)));
		if (r < 79)
			return item_of(CMD_ENTER, int'($urandom_range(0, 65535)));
		if (r < 93)
			return item_of(CMD_LOAD, int'($urandom_range(0, 65535)));
		return item_of(CMD_IDLE, int'($urandom_range(0, 65535)));
	endfunction

	// result side: random stalls, check every transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_setpoint(m_tdata);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 4) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", quiet_cycles);
			$display("tb_joint_home_setpoint_interpolator: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(home_item_t it);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it.d;
		s_tuser <= it.cmd;
		do @(posedge clk); while (!s_tready);
		board.note_item(it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [16:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_reg(idx, v);
		if (idx == CFG_SWITCH_BASE)
			cur_base = int'(v[14:0]);
		else if (idx == CFG_POSE_COUNT)
			cur_count = int'(v[3:0]);
	endtask

	task automatic apply_setting(int b, int c, int st);
		write_reg(CFG_SWITCH_BASE, 17'(b));
		write_reg(CFG_POSE_COUNT, 17'(c));
		write_reg(CFG_PROGRESS_STEP, 17'(st));
		n_settings++;
	endtask

	initial begin
		home_item_t it;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the pose table under reset settings, row 0 first
		for (int p = 0; p < NP; p++) begin
			for (int j = 0; j < NJ; j++) begin
				it = item_of(CMD_LOAD, 0);
				it.d.load_pose = 3'(p);
				it.d.load_joint = 3'(j);
				if (p == 0)
					it.d.load_value = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				send_item(it);
			end
		end

		// single pose: switch commands are consumed but change nothing
		it = item_of(CMD_ENTER, 0);
		for (int j = 0; j < NJ; j++)
			it.d.measured[j] = 32'h8000_0000;
		send_item(it);
		send_item(item_of(CMD_TICK, 3));
		send_item(item_of(CMD_TICK, 2));
		send_item(item_of(CMD_TICK, 32767));
		send_item(item_of(CMD_TICK, -32768));
		// joint index past the last joint writes nothing
		it = item_of(CMD_LOAD, 0);
		it.d.load_pose = 3'd7;
		it.d.load_joint = 3'd6;
		send_item(it);
		it.d.load_joint = 3'd7;
		send_item(it);
		send_item(item_of(CMD_IDLE, 0));
		it = item_of(CMD_ENTER, 0);
		for (int j = 0; j < NJ; j++)
			it.d.measured[j] = 32'h7FFF_FFFF;
		send_item(it);

		// full step saturates at once; cycle, repeat, select, out of range select
		apply_setting(3, 8, 65536);
		send_item(item_of(CMD_TICK, 3));
		send_item(item_of(CMD_TICK, 3));
		send_item(item_of(CMD_TICK, 0));
		send_item(item_of(CMD_TICK, 3));
		send_item(item_of(CMD_TICK, 9));
		send_item(item_of(CMD_TICK, 12));
		send_item(item_of(CMD_TICK, 11));
		// shrink the count under a stale index, then cycle back into range
		write_reg(CFG_POSE_COUNT, 17'd3);
		write_reg(CFG_PROGRESS_STEP, 17'd1);
		send_item(item_of(CMD_TICK, 3));
		send_item(item_of(CMD_TICK, 4));

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: apply_setting(3, 8, 700);
				1: apply_setting(0, 15, 0);
				2: apply_setting(32767, 2, 131071);
				3: apply_setting(10, 0, 2048);
				4: apply_setting(200, 4, 65536);
				5: apply_setting(1, 8, 150);
				default: apply_setting($urandom_range(0, 32767), $urandom_range(2, 8),
					$urandom_range(1, 4096));
			endcase
			for (int i = 0; i < RAND_PHASE_ITEMS; i++) begin
				if (i % 50 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				send_item(random_item());
				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end

		idle_on = 1'b1;
		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d ticks, %0d enters, %0d loads, %0d idle items; %0d setpoints checked",
			board.n_by_cmd[CMD_TICK], board.n_by_cmd[CMD_ENTER], board.n_by_cmd[CMD_LOAD],
			board.n_by_cmd[CMD_IDLE], board.n_checked);
		$display("%0d pose switches over %0d register settings", board.n_switched, n_settings);
		if (board.errors == 0) begin
			$display("tb_joint_home_setpoint_interpolator: PASS");
		end else begin
			$display("tb_joint_home_setpoint_interpolator: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/jhsi_pkg.sv
hw/rtl/joint_home_setpoint_interpolator.sv
tb/tb_joint_home_setpoint_interpolator.sv
